// ===== src/arts_pkg.sv =====
// Shared types, constants and helpers of the axis rotation tensor transform.
package arts_pkg;

    localparam int COMP_W    = 32;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 14;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int OP_W      = 2;
    localparam int N_COMP    = 9;

    // Operand and result widths of the two lane banks.
    localparam int A_XW = COMP_W + 1;
    localparam int A_RW = A_XW + COEF_W + 3 - COEF_FRAC;
    localparam int B_XW = A_RW;
    localparam int B_RW = B_XW + COEF_W + 3 - COEF_FRAC;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd5;

    localparam logic [CFG_W-1:0] ROW_FIRST_RST  = 48'h0000_0000_4000;
    localparam logic [CFG_W-1:0] ROW_SECOND_RST = 48'h0000_4000_0000;
    localparam logic [CFG_W-1:0] ROW_THIRD_RST  = 48'h4000_0000_0000;

    // Component index of tensor element (k, j) for the symmetric form: xx, yy, zz, xy, yz, xz.
    localparam logic [3:0] VOIGT_MAP [N_COMP] = '{
        4'd0, 4'd3, 4'd5,
        4'd3, 4'd1, 4'd4,
        4'd5, 4'd4, 4'd2
    };

    typedef enum logic [OP_W-1:0] {
        OP_POINT   = 2'd0,
        OP_VECTOR  = 2'd1,
        OP_TENSOR9 = 2'd2,
        OP_TENSOR6 = 2'd3
    } t_op;

    typedef struct packed {
        logic vld;
        t_op  op;
    } t_ctl;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [COMP_W-1:0] sat_comp(input logic signed [B_RW-1:0] v);
        logic [B_RW-COMP_W:0] hi;
        logic signed [COMP_W-1:0] r;
        hi = v[B_RW-1:COMP_W-1];
        if (&hi || ~|hi) begin
            r = v[COMP_W-1:0];
        end else if (v[B_RW-1]) begin
            r = {1'b1, {(COMP_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COMP_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== src/arts_in_if.sv =====
// Input channel: one word carries an operation code and nine components.
interface arts_in_if import arts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [COMP_W-1:0] comp_0;
    logic signed [COMP_W-1:0] comp_1;
    logic signed [COMP_W-1:0] comp_2;
    logic signed [COMP_W-1:0] comp_3;
    logic signed [COMP_W-1:0] comp_4;
    logic signed [COMP_W-1:0] comp_5;
    logic signed [COMP_W-1:0] comp_6;
    logic signed [COMP_W-1:0] comp_7;
    logic signed [COMP_W-1:0] comp_8;

    modport source (
        output valid, operation, comp_0, comp_1, comp_2, comp_3, comp_4,
               comp_5, comp_6, comp_7, comp_8,
        input  ready
    );
    modport sink (
        input  valid, operation, comp_0, comp_1, comp_2, comp_3, comp_4,
               comp_5, comp_6, comp_7, comp_8,
        output ready
    );
endinterface

// ===== src/arts_out_if.sv =====
// Output channel: one word carries nine result components.
interface arts_out_if import arts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] result_0;
    logic signed [COMP_W-1:0] result_1;
    logic signed [COMP_W-1:0] result_2;
    logic signed [COMP_W-1:0] result_3;
    logic signed [COMP_W-1:0] result_4;
    logic signed [COMP_W-1:0] result_5;
    logic signed [COMP_W-1:0] result_6;
    logic signed [COMP_W-1:0] result_7;
    logic signed [COMP_W-1:0] result_8;

    modport source (
        output valid, result_0, result_1, result_2, result_3, result_4,
               result_5, result_6, result_7, result_8,
        input  ready
    );
    modport sink (
        input  valid, result_0, result_1, result_2, result_3, result_4,
               result_5, result_6, result_7, result_8,
        output ready
    );
endinterface

// ===== src/arts_lane.sv =====
// One dot-product lane: three Q1.14 by Q16.16 products, bias, round half up.
module arts_lane import arts_pkg::*; #(
    parameter int XW = A_XW
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [COEF_W-1:0]               i_coef [3],
    input  logic signed [XW-1:0]                   i_x    [3],
    input  logic signed [COMP_W-1:0]               i_bias,
    output logic signed [XW+COEF_W+3-COEF_FRAC-1:0] o_res
);
    localparam int PW = XW + COEF_W;
    localparam int SW = PW + 3;
    localparam int RW = SW - COEF_FRAC;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (COEF_FRAC - 1);

    logic signed [PW-1:0]     r_prod [3];
    logic signed [COMP_W-1:0] r_bias;
    logic signed [RW-1:0]     r_res;
    logic signed [SW-1:0]     sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= PW'(i_coef[k]) * PW'(i_x[k]);
            end
            r_bias <= i_bias;
        end
    end

    // The bias is an origin term in Q16.16, lifted to the product scale.
    always_comb begin
        sum = SW'(r_prod[0]) + SW'(r_prod[1]) + SW'(r_prod[2])
            + (SW'(r_bias) <<< COEF_FRAC) + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= RW'(sum >>> COEF_FRAC);
        end
    end

    assign o_res = r_res;
endmodule

// ===== src/arts_merge.sv =====
// Result merge: picks the layout for the operation, saturates, holds the word.
module arts_merge import arts_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_ctl                     i_ctl,
    input  logic signed [A_RW-1:0]   i_vec  [3],
    input  logic signed [B_RW-1:0]   i_tens [3][3],
    output logic                     o_vld,
    output logic signed [COMP_W-1:0] o_res  [N_COMP]
);
    logic                     r_vld;
    logic signed [COMP_W-1:0] r_res [N_COMP];
    logic signed [COMP_W-1:0] n_res [N_COMP];

    always_comb begin
        for (int n = 0; n < N_COMP; n++) begin
            n_res[n] = '0;
        end
        unique case (i_ctl.op)
            OP_POINT, OP_VECTOR: begin
                for (int i = 0; i < 3; i++) begin
                    n_res[i] = sat_comp(B_RW'(i_vec[i]));
                end
            end
            OP_TENSOR9: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        n_res[3*i+j] = sat_comp(i_tens[i][j]);
                    end
                end
            end
            OP_TENSOR6: begin
                n_res[0] = sat_comp(i_tens[0][0]);
                n_res[1] = sat_comp(i_tens[1][1]);
                n_res[2] = sat_comp(i_tens[2][2]);
                n_res[3] = sat_comp(i_tens[0][1]);
                n_res[4] = sat_comp(i_tens[1][2]);
                n_res[5] = sat_comp(i_tens[0][2]);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;
endmodule

// ===== src/axis_rotation_tensor_transform.sv =====
// Top level of the axis rotation tensor transform.
//
// Usage: configure the three matrix rows (Q1.14 coefficients) and the axis
// origin through the write port while the block is idle, then stream words
// on i_in. Each word carries an operation code and nine Q16.16 components;
// each result word on o_out carries nine saturated Q16.16 components.
// Point mode rotates about the origin, vector mode by the matrix alone, and
// the two tensor modes compute R*T*R^T on a full or a symmetric tensor.
// The block takes one word every cycle while the output is not stalled: a
// bank of nine lanes forms R*T, a second bank of nine lanes forms (R*T)*R^T,
// and each lane registers its three products and then its rounded sum.
// Reset loads the identity matrix and a zero origin and empties the pipe.
// When the receiver stalls, the pipeline holds and a one-word skid buffer
// at the input takes the word that was already offered; i_in.ready comes
// straight from a register.
module axis_rotation_tensor_transform import arts_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    arts_in_if.sink              i_in,
    arts_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    logic [CFG_W-1:0]         r_row [3];
    logic signed [COMP_W-1:0] r_org [3];
    logic signed [COEF_W-1:0] mat   [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW_FIRST_RST;
            r_row[1] <= ROW_SECOND_RST;
            r_row[2] <= ROW_THIRD_RST;
            for (int i = 0; i < 3; i++) begin
                r_org[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_FIRST:  r_row[0] <= i_cfg_data;
                CFG_ROW_SECOND: r_row[1] <= i_cfg_data;
                CFG_ROW_THIRD:  r_row[2] <= i_cfg_data;
                CFG_ORIGIN_X:   r_org[0] <= i_cfg_data[COMP_W-1:0];
                CFG_ORIGIN_Y:   r_org[1] <= i_cfg_data[COMP_W-1:0];
                CFG_ORIGIN_Z:   r_org[2] <= i_cfg_data[COMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mat[i][j] = r_row[i][COEF_W*j +: COEF_W];
            end
        end
    end

    // Input skid buffer and pipeline advance.
    logic                     adv;
    logic                     out_vld;
    logic                     in_acc;
    logic                     r_skid_vld;
    t_op                      r_skid_op;
    logic signed [COMP_W-1:0] r_skid_comp [N_COMP];
    logic signed [COMP_W-1:0] in_comp     [N_COMP];
    logic signed [COMP_W-1:0] src_comp    [N_COMP];
    t_op                      src_op;
    logic                     src_vld;

    assign adv          = ~out_vld | o_out.ready;
    assign i_in.ready   = ~r_skid_vld;
    assign in_acc       = i_in.valid & ~r_skid_vld;
    assign in_comp      = '{i_in.comp_0, i_in.comp_1, i_in.comp_2,
                            i_in.comp_3, i_in.comp_4, i_in.comp_5,
                            i_in.comp_6, i_in.comp_7, i_in.comp_8};
    assign src_vld      = r_skid_vld | in_acc;
    assign src_op       = r_skid_vld ? r_skid_op : t_op'(i_in.operation);
    assign src_comp     = r_skid_vld ? r_skid_comp : in_comp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (adv) begin
            r_skid_vld <= 1'b0;
        end else if (in_acc) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!adv && in_acc) begin
            r_skid_op   <= t_op'(i_in.operation);
            r_skid_comp <= in_comp;
        end
    end

    // Operand stage: columns of the left-hand operand and the origin bias.
    logic signed [A_XW-1:0]   n_x    [3][3];
    logic signed [A_XW-1:0]   r_x    [3][3];
    logic signed [COMP_W-1:0] n_bias [3];
    logic signed [COMP_W-1:0] r_bias [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_bias[k] = '0;
            for (int j = 0; j < 3; j++) begin
                n_x[k][j] = '0;
            end
        end
        unique case (src_op)
            OP_POINT: begin
                for (int k = 0; k < 3; k++) begin
                    n_x[k][0] = A_XW'(src_comp[k]) - A_XW'(r_org[k]);
                    n_bias[k] = r_org[k];
                end
            end
            OP_VECTOR: begin
                for (int k = 0; k < 3; k++) begin
                    n_x[k][0] = A_XW'(src_comp[k]);
                end
            end
            OP_TENSOR9: begin
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < 3; j++) begin
                        n_x[k][j] = A_XW'(src_comp[3*k+j]);
                    end
                end
            end
            OP_TENSOR6: begin
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < 3; j++) begin
                        n_x[k][j] = A_XW'(src_comp[VOIGT_MAP[3*k+j]]);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x    <= n_x;
            r_bias <= n_bias;
        end
    end

    // Control travels alongside the data: operand, two A stages, two B stages.
    t_ctl r_ctl [5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 5; s++) begin
                r_ctl[s] <= '{vld: 1'b0, op: OP_POINT};
            end
        end else if (adv) begin
            r_ctl[0] <= '{vld: src_vld, op: src_op};
            for (int s = 1; s < 5; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // First bank: tmp = R * X. In point and vector modes only column 0 matters.
    logic signed [A_RW-1:0] a_res [3][3];
    logic signed [B_RW-1:0] b_res [3][3];

    for (genvar i = 0; i < 3; i++) begin : g_a_row
        for (genvar j = 0; j < 3; j++) begin : g_a_col
            logic signed [A_XW-1:0]   a_x [3];
            logic signed [COMP_W-1:0] a_bias;

            assign a_x    = '{r_x[0][j], r_x[1][j], r_x[2][j]};
            assign a_bias = (j == 0) ? r_bias[i] : '0;

            arts_lane #(.XW(A_XW)) u_lane_a (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_coef (mat[i]),
                .i_x    (a_x),
                .i_bias (a_bias),
                .o_res  (a_res[i][j])
            );
        end
    end

    // Second bank: out[i][j] = sum over k of tmp[i][k] * R[j][k].
    for (genvar i = 0; i < 3; i++) begin : g_b_row
        for (genvar j = 0; j < 3; j++) begin : g_b_col
            arts_lane #(.XW(B_XW)) u_lane_b (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_coef (mat[j]),
                .i_x    (a_res[i]),
                .i_bias ('0),
                .o_res  (b_res[i][j])
            );
        end
    end

    // Point and vector results skip the second bank and wait beside it.
    logic signed [A_RW-1:0] r_vec1 [3];
    logic signed [A_RW-1:0] r_vec2 [3];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_vec1[i] <= a_res[i][0];
                r_vec2[i] <= r_vec1[i];
            end
        end
    end

    logic signed [COMP_W-1:0] res [N_COMP];

    arts_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_ctl   (r_ctl[4]),
        .i_vec   (r_vec2),
        .i_tens  (b_res),
        .o_vld   (out_vld),
        .o_res   (res)
    );

    assign o_out.valid    = out_vld;
    assign o_out.result_0 = res[0];
    assign o_out.result_1 = res[1];
    assign o_out.result_2 = res[2];
    assign o_out.result_3 = res[3];
    assign o_out.result_4 = res[4];
    assign o_out.result_5 = res[5];
    assign o_out.result_6 = res[6];
    assign o_out.result_7 = res[7];
    assign o_out.result_8 = res[8];
endmodule

// ===== tb/arts_transform_checker.sv =====
// Watches both channels and the write port, predicts each result word and compares it.
`timescale 1ns / 100ps

module arts_transform_checker import arts_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    arts_in_if                   i_in_mon,
    arts_out_if                  i_out_mon,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef logic [N_COMP-1:0][COMP_W-1:0] t_tuple;

    localparam int     MAX_REPORTS = 10;
    localparam longint COMP_MAX    = 64'sd2147483647;
    localparam longint COMP_MIN    = -64'sd2147483648;

    logic [CFG_W-1:0]  row_reg    [3];
    logic [COMP_W-1:0] origin_reg [3];
    t_tuple            rotated_q  [$];
    int                fail_total;
    int                in_flight;

    assign o_fail_count = fail_total;
    assign o_pending    = in_flight;

    // Round to nearest with ties toward +infinity, dropping the Q1.14 fraction.
    function automatic longint round_q14(input longint x);
        return (x + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    endfunction

    function automatic logic [COMP_W-1:0] clamp_q16(input longint x);
        if (x > COMP_MAX) begin
            return COMP_MAX[COMP_W-1:0];
        end else if (x < COMP_MIN) begin
            return COMP_MIN[COMP_W-1:0];
        end
        return x[COMP_W-1:0];
    endfunction

    function automatic t_tuple rotate_tuple(input t_op op, input t_tuple comp);
        longint m   [3][3];
        longint c   [N_COMP];
        longint ten [3][3];
        longint rt  [3][3];
        longint r   [3][3];
        longint off [3];
        longint acc;
        t_tuple res;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m[i][j] = longint'($signed(row_reg[i][COEF_W*j +: COEF_W]));
            end
        end
        for (int i = 0; i < N_COMP; i++) begin
            c[i] = longint'($signed(comp[i]));
        end
        if (op == OP_POINT || op == OP_VECTOR) begin
            // A vector is a point about a zero origin; the offset stays exact.
            for (int i = 0; i < 3; i++) begin
                off[i] = (op == OP_POINT) ? longint'($signed(origin_reg[i])) : 0;
            end
            for (int i = 0; i < 3; i++) begin
                acc = off[i] <<< COEF_FRAC;
                for (int k = 0; k < 3; k++) begin
                    acc += m[i][k] * (c[k] - off[k]);
                end
                res[i] = clamp_q16(round_q14(acc));
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    ten[i][j] = (op == OP_TENSOR9) ? c[3*i + j] : c[VOIGT_MAP[3*i + j]];
                end
            end
            // R*T is rounded but kept at full width before the second product.
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    acc = 0;
                    for (int k = 0; k < 3; k++) begin
                        acc += m[i][k] * ten[k][j];
                    end
                    rt[i][j] = round_q14(acc);
                end
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    acc = 0;
                    for (int k = 0; k < 3; k++) begin
                        acc += rt[i][k] * m[j][k];
                    end
                    r[i][j] = round_q14(acc);
                end
            end
            if (op == OP_TENSOR9) begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        res[3*i + j] = clamp_q16(r[i][j]);
                    end
                end
            end else begin
                res[0] = clamp_q16(r[0][0]);
                res[1] = clamp_q16(r[1][1]);
                res[2] = clamp_q16(r[2][2]);
                res[3] = clamp_q16(r[0][1]);
                res[4] = clamp_q16(r[1][2]);
                res[5] = clamp_q16(r[0][2]);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_tuple got;
        t_tuple want;
        t_tuple comps;
        if (!i_rst_n) begin
            row_reg[0]    <= ROW_FIRST_RST;
            row_reg[1]    <= ROW_SECOND_RST;
            row_reg[2]    <= ROW_THIRD_RST;
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            rotated_q.delete();
            fail_total = 0;
            in_flight  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROW_FIRST:  row_reg[0]    <= i_cfg_data;
                    CFG_ROW_SECOND: row_reg[1]    <= i_cfg_data;
                    CFG_ROW_THIRD:  row_reg[2]    <= i_cfg_data;
                    CFG_ORIGIN_X:   origin_reg[0] <= i_cfg_data[COMP_W-1:0];
                    CFG_ORIGIN_Y:   origin_reg[1] <= i_cfg_data[COMP_W-1:0];
                    CFG_ORIGIN_Z:   origin_reg[2] <= i_cfg_data[COMP_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = {i_out_mon.result_8, i_out_mon.result_7, i_out_mon.result_6,
                       i_out_mon.result_5, i_out_mon.result_4, i_out_mon.result_3,
                       i_out_mon.result_2, i_out_mon.result_1, i_out_mon.result_0};
                if (rotated_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= MAX_REPORTS) begin
                        $display("Unexpected result word %h at %0t", got, $realtime);
                    end
                end else begin
                    want = rotated_q.pop_front();
                    for (int f = 0; f < N_COMP; f++) begin
                        if (got[f] !== want[f]) begin
                            fail_total++;
                            if (fail_total <= MAX_REPORTS) begin
                                $display("Mismatch on result_%0d at %0t: expected %h, got %h",
                                         f, $realtime, want[f], got[f]);
                            end
                        end
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                comps = {i_in_mon.comp_8, i_in_mon.comp_7, i_in_mon.comp_6,
                         i_in_mon.comp_5, i_in_mon.comp_4, i_in_mon.comp_3,
                         i_in_mon.comp_2, i_in_mon.comp_1, i_in_mon.comp_0};
                rotated_q.insert(rotated_q.size(),
                                 rotate_tuple(t_op'(i_in_mon.operation), comps));
            end
            in_flight = rotated_q.size();
        end
    end

endmodule

// ===== tb/tb_axis_rotation_tensor_transform.sv =====
// Stimulus, flow control and verdict for the axis rotation tensor transform.
`timescale 1ns / 100ps

module tb_axis_rotation_tensor_transform;
    import arts_pkg::*;

    typedef logic [N_COMP-1:0][COMP_W-1:0] t_tuple;
    typedef enum int {XF_ROTATION, XF_ARBITRARY, XF_EXTREME} t_xform;
    typedef enum int {SINK_FREE, SINK_RANDOM, SINK_PERIODIC, SINK_CHOKED} t_sink;

    localparam int RUN_LIMIT_NS = 4_000_000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 250;
    localparam int SETTLE_CYCLES = 16;

    localparam logic [COMP_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [COMP_W-1:0] Q_MIN  = 32'h8000_0000;
    localparam logic [COMP_W-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [COMP_W-1:0] Q_NEG1 = 32'hFFFF_FFFF;
    localparam logic [COEF_W-1:0] ONE_Q14 = 16'h4000;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   burst_left;

    arts_in_if  in_ch ();
    arts_out_if out_ch ();

    axis_rotation_tensor_transform dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    arts_transform_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    function automatic t_tuple tuple9(input logic [COMP_W-1:0] c0, c1, c2, c3, c4,
                                      c5, c6, c7, c8);
        t_tuple t;
        t = {c8, c7, c6, c5, c4, c3, c2, c1, c0};
        return t;
    endfunction

    // Full-range values most often, with small, medium and boundary values mixed in.
    function automatic logic [COMP_W-1:0] rand_comp();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return r;
            4, 5:       return {{11{r[20]}}, r[20:0]};
            6, 7:       return {{4{r[27]}}, r[27:0]};
            default: begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return Q_NEG1;
                    default: return Q_ONE;
                endcase
            end
        endcase
    endfunction

    function automatic logic [2:0][CFG_W-1:0] random_matrix(input t_xform kind);
        logic signed [COEF_W-1:0] m [3][3];
        logic signed [COEF_W-1:0] cq;
        logic signed [COEF_W-1:0] sq;
        logic [2:0][CFG_W-1:0]    rows;
        real                      ang;
        int                       a;
        int                       i;
        int                       j;
        for (int r = 0; r < 3; r++) begin
            for (int col = 0; col < 3; col++) begin
                m[r][col] = '0;
            end
        end
        case (kind)
            XF_ROTATION: begin
                // A rotation about one coordinate axis, with rounded Q1.14 cosine and sine.
                ang = real'($urandom_range(0, 359999)) * 6.283185307179586 / 360000.0;
                cq  = COEF_W'($rtoi($floor($cos(ang) * 16384.0 + 0.5)));
                sq  = COEF_W'($rtoi($floor($sin(ang) * 16384.0 + 0.5)));
                a   = $urandom_range(0, 2);
                i   = (a + 1) % 3;
                j   = (a + 2) % 3;
                m[a][a] = ONE_Q14;
                m[i][i] = cq;
                m[i][j] = -sq;
                m[j][i] = sq;
                m[j][j] = cq;
            end
            XF_ARBITRARY: begin
                for (int r = 0; r < 3; r++) begin
                    for (int col = 0; col < 3; col++) begin
                        m[r][col] = COEF_W'($urandom);
                    end
                end
            end
            default: begin
                for (int r = 0; r < 3; r++) begin
                    for (int col = 0; col < 3; col++) begin
                        case ($urandom_range(0, 6))
                            0: m[r][col] = 16'sh8000;
                            1: m[r][col] = 16'sh7FFF;
                            2: m[r][col] = 16'sh0000;
                            3: m[r][col] = 16'sh4000;
                            4: m[r][col] = 16'shC000;
                            5: m[r][col] = 16'sh0001;
                            default: m[r][col] = 16'shFFFF;
                        endcase
                    end
                end
            end
        endcase
        for (int r = 0; r < 3; r++) begin
            rows[r] = {m[r][2], m[r][1], m[r][0]};
        end
        return rows;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
    endtask

    // Origin writes carry junk above bit 31, which the block must drop.
    task automatic load_transform(input logic [CFG_W-1:0] row0, row1, row2,
                                  input logic [COMP_W-1:0] ox, oy, oz);
        cfg_write(CFG_ROW_FIRST, row0);
        cfg_write(CFG_SPARE_LO, {16'($urandom), 32'($urandom)});
        cfg_write(CFG_ROW_SECOND, row1);
        cfg_write(CFG_ROW_THIRD, row2);
        cfg_write(CFG_ORIGIN_X, {16'($urandom), ox});
        cfg_write(CFG_ORIGIN_Y, {16'($urandom), oy});
        cfg_write(CFG_SPARE_HI, {16'($urandom), 32'($urandom)});
        cfg_write(CFG_ORIGIN_Z, {16'($urandom), oz});
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Offers one word and waits for it to be taken; bursts end in random gaps.
    task automatic send_word(input t_op op, input t_tuple comp);
        int gap;
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.comp_0    <= comp[0];
        in_ch.comp_1    <= comp[1];
        in_ch.comp_2    <= comp[2];
        in_ch.comp_3    <= comp[3];
        in_ch.comp_4    <= comp[4];
        in_ch.comp_5    <= comp[5];
        in_ch.comp_6    <= comp[6];
        in_ch.comp_7    <= comp[7];
        in_ch.comp_8    <= comp[8];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // The receiver switches between free flow and several stall patterns.
    initial begin : sink_stall
        t_sink mode;
        int    span;
        out_ch.ready = 1'b0;
        forever begin
            mode = t_sink'($urandom_range(0, 3));
            span = $urandom_range(16, 160);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    SINK_FREE:     out_ch.ready <= 1'b1;
                    SINK_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
                    SINK_PERIODIC: out_ch.ready <= ((k % 5) < 3);
                    default:       out_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [2:0][CFG_W-1:0] mat;
        t_tuple                tup;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = '0;
        in_ch.comp_0    = '0;
        in_ch.comp_1    = '0;
        in_ch.comp_2    = '0;
        in_ch.comp_3    = '0;
        in_ch.comp_4    = '0;
        in_ch.comp_5    = '0;
        in_ch.comp_6    = '0;
        in_ch.comp_7    = '0;
        in_ch.comp_8    = '0;
        burst_left      = $urandom_range(1, 40);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Identity matrix and zero origin from reset; unused fields carry zeros, noise or extreme values.
        send_word(OP_POINT, tuple9('0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_word(OP_POINT, tuple9(Q_MAX, Q_MIN, Q_NEG1, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom));
        send_word(OP_VECTOR, tuple9(Q_MIN, Q_MAX, 32'd1, Q_MAX, Q_MAX, Q_MAX,
                                    Q_MIN, Q_MIN, Q_MIN));
        send_word(OP_TENSOR9, tuple9(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                     Q_MAX, Q_MAX, Q_MAX));
        send_word(OP_TENSOR9, tuple9(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                     Q_MIN, Q_MIN, Q_MIN));
        send_word(OP_TENSOR6, tuple9(Q_MAX, Q_MIN, Q_ONE, Q_NEG1, Q_MAX, Q_MIN,
                                     $urandom, $urandom, $urandom));
        send_word(OP_TENSOR9, tuple9($urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom));

        // Every coefficient at -2.0 and the origin's x and y at the range ends, so
        // the point offset needs its 33rd bit and the results saturate.
        wait_idle();
        load_transform(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                       Q_MAX, Q_MIN, '0);
        send_word(OP_POINT, tuple9(Q_MIN, Q_MAX, Q_MAX, '0, '0, '0, '0, '0, '0));
        send_word(OP_POINT, tuple9(Q_MAX, Q_MIN, Q_MIN, '0, '0, '0, '0, '0, '0));
        send_word(OP_VECTOR, tuple9(Q_MAX, Q_MAX, Q_MAX, '0, '0, '0, '0, '0, '0));
        send_word(OP_VECTOR, tuple9(Q_MIN, Q_MIN, Q_MIN, '0, '0, '0, '0, '0, '0));
        send_word(OP_TENSOR9, tuple9(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                                     Q_MAX, Q_MIN, Q_MAX));
        send_word(OP_TENSOR6, tuple9(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                     '0, '0, '0));

        // Row one holds +0.5 and -0.5, so single-LSB inputs land on rounding ties.
        wait_idle();
        load_transform(48'h7FFF_7FFF_7FFF, 48'h0000_E000_2000, 48'h0001_7FFF_8000,
                       Q_MIN, Q_MAX, Q_NEG1);
        send_word(OP_POINT, tuple9(Q_MAX, Q_MIN, '0, '0, '0, '0, '0, '0, '0));
        send_word(OP_VECTOR, tuple9(32'd1, '0, '0, '0, '0, '0, '0, '0, '0));
        send_word(OP_VECTOR, tuple9(Q_NEG1, '0, '0, '0, '0, '0, '0, '0, '0));
        send_word(OP_VECTOR, tuple9('0, 32'd1, '0, '0, '0, '0, '0, '0, '0));
        send_word(OP_TENSOR9, tuple9(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                     Q_MAX, Q_MAX, Q_MAX));
        send_word(OP_TENSOR6, tuple9(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                     Q_MAX, Q_MAX, Q_MAX));
        send_word(OP_TENSOR6, tuple9(32'd3, Q_NEG1, 32'd1, 32'd2, Q_NEG1, 32'd1,
                                     '0, '0, '0));

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            mat = random_matrix(t_xform'(ph % 3));
            load_transform(mat[0], mat[1], mat[2], rand_comp(), rand_comp(), rand_comp());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                for (int f = 0; f < N_COMP; f++) begin
                    tup[f] = rand_comp();
                end
                send_word(t_op'($urandom_range(0, 3)), tup);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/arts_pkg.sv
src/arts_in_if.sv
src/arts_out_if.sv
src/arts_lane.sv
src/arts_merge.sv
src/axis_rotation_tensor_transform.sv
tb/arts_transform_checker.sv
tb/tb_axis_rotation_tensor_transform.sv
